// ===== rtl/mst_pkg.sv =====
// shared types and constants of the multi-slot countdown timer
package mst_pkg;

  localparam int unsigned SLOT_COUNT = 8;
  localparam int unsigned SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned OP_W       = 3;
  localparam int unsigned ID_W       = 4;
  localparam int unsigned IVAL_W     = 32;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned SLOT_OUT_W = 3;

  typedef enum logic [OP_W-1:0] {
    OP_ADD_ONCE   = 3'd0,
    OP_ADD_REPEAT = 3'd1,
    OP_UPDATE     = 3'd2,
    OP_STOP       = 3'd3,
    OP_TICK       = 3'd4
  } op_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_REPLY  = 2'd0,
    KIND_EXPIRY = 2'd1,
    KIND_NONE   = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_LOAD,
    ST_SEND
  } state_e;

  typedef struct packed {
    logic load;
    logic exec;
    logic scan_step;
    logic res_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic tick;
    logic scan_last;
    logic exp_pending;
  } ctrl_status_t;

endpackage

// ===== rtl/mst_if.sv =====
// command and result channel interfaces
interface mst_cmd_if;
  import mst_pkg::*;
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic [ID_W-1:0]     slot_id;
  logic [IVAL_W-1:0]   interval;
  modport source (output valid, output op, output slot_id, output interval, input ready);
  modport sink   (input valid, input op, input slot_id, input interval, output ready);
endinterface

interface mst_res_if;
  import mst_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [KIND_W-1:0]     kind;
  logic [SLOT_OUT_W-1:0] slot;
  logic                  ok;
  logic                  last;
  modport source (output valid, output kind, output slot, output ok, output last, input ready);
  modport sink   (input valid, input kind, input slot, input ok, input last, output ready);
endinterface

// ===== rtl/mst_ctrl.sv =====
// sequencing state machine of the timer table
module mst_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  mst_pkg::ctrl_status_t status_i,
  output mst_pkg::ctrl_cmd_t    cmd_o
);
  import mst_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = status_i.tick ? ST_SCAN : ST_SEND;
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (status_i.scan_last) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd_o.res_load = 1'b1;
        state_d        = ST_SEND;
      end
      ST_SEND: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = status_i.exp_pending ? ST_LOAD : ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/mst_dpath.sv =====
// slot storage, command execution and tick scan
module mst_dpath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mst_pkg::ctrl_cmd_t            cmd_i,
  output mst_pkg::ctrl_status_t         status_o,
  input  logic [mst_pkg::OP_W-1:0]      op_i,
  input  logic [mst_pkg::ID_W-1:0]      slot_id_i,
  input  logic [mst_pkg::IVAL_W-1:0]    interval_i,
  output logic [mst_pkg::KIND_W-1:0]    kind_o,
  output logic [mst_pkg::SLOT_OUT_W-1:0] slot_o,
  output logic                          ok_o,
  output logic                          last_o
);
  import mst_pkg::*;

  logic [SLOT_COUNT-1:0] act_q, act_d;
  logic [SLOT_COUNT-1:0] rep_q, rep_d;
  logic [SLOT_COUNT-1:0] exp_q, exp_d;
  logic [SLOT_W-1:0]     idx_q, idx_d;
  logic [IVAL_W-1:0]     cd_q [SLOT_COUNT];
  logic [IVAL_W-1:0]     rl_q [SLOT_COUNT];

  op_e                   op_q;
  logic [ID_W-1:0]       id_q;
  logic [IVAL_W-1:0]     ival_q;

  kind_e                 kind_q, kind_d;
  logic [SLOT_OUT_W-1:0] slot_q, slot_d;
  logic                  ok_q, ok_d;
  logic                  last_q, last_d;

  logic                  cd_we, rl_we;
  logic [SLOT_W-1:0]     wr_addr;
  logic [IVAL_W-1:0]     cd_wdata;

  logic                  free_found;
  logic [SLOT_W-1:0]     free_idx;
  logic [SLOT_W-1:0]     exp_idx;
  logic [SLOT_COUNT-1:0] exp_rest;
  logic                  id_valid;
  logic [SLOT_W-1:0]     id_idx;
  logic [IVAL_W-1:0]     cd_dec;

  // lowest free slot and lowest pending expiry
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    exp_idx    = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!act_q[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
      if (exp_q[i]) begin
        exp_idx = SLOT_W'(i);
      end
    end
  end

  assign exp_rest = exp_q & ~(SLOT_COUNT'(1) << exp_idx);
  assign id_valid = {1'b0, id_q} < (ID_W + 1)'(SLOT_COUNT);
  assign id_idx   = id_q[SLOT_W-1:0];
  assign cd_dec   = cd_q[idx_q] - IVAL_W'(1);

  always_comb begin
    act_d    = act_q;
    rep_d    = rep_q;
    exp_d    = exp_q;
    idx_d    = idx_q;
    kind_d   = kind_q;
    slot_d   = slot_q;
    ok_d     = ok_q;
    last_d   = last_q;
    cd_we    = 1'b0;
    rl_we    = 1'b0;
    wr_addr  = free_idx;
    cd_wdata = ival_q;

    if (cmd_i.exec) begin
      kind_d = KIND_REPLY;
      slot_d = '0;
      ok_d   = 1'b0;
      last_d = 1'b1;
      unique case (op_q)
        OP_ADD_ONCE, OP_ADD_REPEAT, OP_UPDATE: begin
          if (op_q == OP_UPDATE && id_valid && act_q[id_idx]) begin
            wr_addr = id_idx;
            cd_we   = 1'b1;
            rl_we   = 1'b1;
            slot_d  = SLOT_OUT_W'(id_idx);
            ok_d    = 1'b1;
          end else if (free_found) begin
            cd_we           = 1'b1;
            rl_we           = 1'b1;
            act_d[free_idx] = 1'b1;
            rep_d[free_idx] = (op_q == OP_ADD_REPEAT);
            slot_d          = SLOT_OUT_W'(free_idx);
            ok_d            = 1'b1;
          end
        end
        OP_STOP: begin
          if (id_valid && act_q[id_idx]) begin
            act_d[id_idx] = 1'b0;
            slot_d        = SLOT_OUT_W'(id_idx);
            ok_d          = 1'b1;
          end
        end
        OP_TICK: begin
          exp_d = '0;
          idx_d = '0;
        end
        default: ;
      endcase
    end

    if (cmd_i.scan_step) begin
      wr_addr = idx_q;
      if (act_q[idx_q]) begin
        cd_we    = 1'b1;
        cd_wdata = cd_dec;
        if (cd_dec == '0) begin
          exp_d[idx_q] = 1'b1;
          if (rep_q[idx_q]) begin
            cd_wdata = rl_q[idx_q];
          end else begin
            act_d[idx_q] = 1'b0;
          end
        end
      end
      idx_d = idx_q + SLOT_W'(1);
    end

    if (cmd_i.res_load) begin
      if (exp_q == '0) begin
        kind_d = KIND_NONE;
        slot_d = '0;
      end else begin
        kind_d = KIND_EXPIRY;
        slot_d = SLOT_OUT_W'(exp_idx);
        exp_d  = exp_rest;
      end
      ok_d   = 1'b1;
      last_d = (exp_rest == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= '0;
      rep_q <= '0;
      exp_q <= '0;
      idx_q <= '0;
    end else begin
      act_q <= act_d;
      rep_q <= rep_d;
      exp_q <= exp_d;
      idx_q <= idx_d;
    end
  end

  // slot counters and reload values
  always_ff @(posedge clk_i) begin
    if (cd_we) begin
      cd_q[wr_addr] <= cd_wdata;
    end
    if (rl_we) begin
      rl_q[wr_addr] <= ival_q;
    end
  end

  // latched command and result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= op_e'(op_i);
      id_q   <= slot_id_i;
      ival_q <= (interval_i == '0) ? IVAL_W'(1) : interval_i;
    end
    kind_q <= kind_d;
    slot_q <= slot_d;
    ok_q   <= ok_d;
    last_q <= last_d;
  end

  assign status_o.tick        = (op_q == OP_TICK);
  assign status_o.scan_last   = (idx_q == SLOT_W'(SLOT_COUNT - 1));
  assign status_o.exp_pending = (exp_q != '0);

  assign kind_o = kind_q;
  assign slot_o = slot_q;
  assign ok_o   = ok_q;
  assign last_o = last_q;

endmodule

// ===== rtl/multi_slot_countdown_timer.sv =====
// top level of the multi-slot countdown timer table
//
// cmd_i carries one command per transfer: add one-shot, add repeating,
// update, stop or tick, with a slot id and an interval in ticks.
// res_o carries the results: one reply per add, update or stop, and for a
// tick one expiry event per slot that reached zero in ascending slot order,
// or a single no-expiry result; last marks the final result of a command.
// one command is handled at a time: cmd_i.ready is high only while idle.
// a command other than tick goes from the transfer through the exec state
// to the send state, where its result is offered. a tick walks the slot
// counters one slot per cycle, then passes through the load and send
// states once per result; the counter scan sets the tick rate.
// when res_o.ready is low the pending result holds and no command is taken.
// reset frees all slots and leaves the block idle, ready for a command;
// no clearing pass is needed.
module multi_slot_countdown_timer (
  input  logic      clk_i,
  input  logic      rst_ni,
  mst_cmd_if.sink   cmd_i,
  mst_res_if.source res_o
);
  import mst_pkg::*;

  ctrl_cmd_t    ctrl_cmd;
  ctrl_status_t ctrl_status;

  mst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (cmd_i.valid),
    .in_ready_o  (cmd_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .status_i    (ctrl_status),
    .cmd_o       (ctrl_cmd)
  );

  mst_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (ctrl_cmd),
    .status_o   (ctrl_status),
    .op_i       (cmd_i.op),
    .slot_id_i  (cmd_i.slot_id),
    .interval_i (cmd_i.interval),
    .kind_o     (res_o.kind),
    .slot_o     (res_o.slot),
    .ok_o       (res_o.ok),
    .last_o     (res_o.last)
  );

  a_no_accept_while_result : assert property (
    @(posedge clk_i) disable iff (!rst_ni) res_o.valid |-> !cmd_i.ready
  ) else $error("command taken while a result is pending");

  a_busy_after_accept : assert property (
    @(posedge clk_i) disable iff (!rst_ni) (cmd_i.valid && cmd_i.ready) |=> !cmd_i.ready
  ) else $error("ready after command transfer");

  a_reply_is_last : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      (res_o.valid && (res_o.kind == KIND_REPLY || res_o.kind == KIND_NONE)) |-> res_o.last
  ) else $error("single result without last");

  a_none_is_slot_zero : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      (res_o.valid && res_o.kind == KIND_NONE) |-> (res_o.slot == '0 && res_o.ok)
  ) else $error("bad no-expiry result");

endmodule
